@@ design/assert_macros.svh @@
// Assertion macros used by the divider RTL.
// Relies on the including module providing clock and reset signals.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ design/sid_pkg.sv @@
// Shared types and constants for the signed integer divider.
// No dependencies; imported by every divider module.
`timescale 1ns / 1ps

package sid_pkg;

   // Operand and quotient width
   localparam int DATA_W = 32;

   localparam logic [DATA_W-1:0] SIGN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
   localparam logic [DATA_W-1:0] MAX_POS  = {1'b0, {(DATA_W-1){1'b1}}};

   // Partial state carried from one cell to the next
   typedef struct packed {
      logic [DATA_W-1:0] rem;   // partial remainder
      logic [DATA_W-1:0] nq;    // dividend bits still to shift in, quotient bits shifted out
      logic [DATA_W-1:0] den;   // divisor magnitude
      logic              neg;   // negate the final quotient
      logic              sat;   // saturate to the largest positive value
   } sid_work_type;

endpackage

@@ design/sid_prep.sv @@
// Input stage of the divider: magnitudes, sign and saturation flags.
// Depends on sid_pkg.
`timescale 1ns / 1ps

module sid_prep (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [sid_pkg::DATA_W-1:0] req_dividend,
   input  logic signed [sid_pkg::DATA_W-1:0] req_divisor,
   output logic                           out_valid,
   input  logic                           out_ready,
   output sid_pkg::sid_work_type          out_work
);
   import sid_pkg::*;

   logic         valid_ff;
   sid_work_type work_ff;
   sid_work_type work_in;
   logic         a_neg;
   logic         d_neg;

   // Form magnitudes and flag the saturating cases
   always_comb begin
      a_neg        = req_dividend[DATA_W-1];
      d_neg        = req_divisor[DATA_W-1];
      work_in.rem  = '0;
      work_in.nq   = a_neg ? (DATA_W'(0) - DATA_W'(req_dividend)) : DATA_W'(req_dividend);
      work_in.den  = d_neg ? (DATA_W'(0) - DATA_W'(req_divisor)) : DATA_W'(req_divisor);
      work_in.neg  = a_neg ^ d_neg;
      work_in.sat  = (req_divisor == '0) ||
                     ((DATA_W'(req_dividend) == SIGN_VAL) && (DATA_W'(req_divisor) == ALL_ONES));
   end

   assign req_ready = !valid_ff || out_ready;

   // Hold or advance the stage register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_ready && req_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

@@ design/sid_cell.sv @@
// One restoring division cell: resolves one quotient bit per transfer.
// Depends on sid_pkg.
`timescale 1ns / 1ps

module sid_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  sid_pkg::sid_work_type in_work,
   output logic                  out_valid,
   input  logic                  out_ready,
   output sid_pkg::sid_work_type out_work
);
   import sid_pkg::*;

   logic              valid_ff;
   sid_work_type      work_ff;
   sid_work_type      work_in;
   logic [DATA_W:0]   trial;
   logic [DATA_W:0]   diff;

   // Shift in the next dividend bit and try the subtraction
   always_comb begin
      trial   = {in_work.rem, in_work.nq[DATA_W-1]};
      diff    = trial - {1'b0, in_work.den};
      work_in = in_work;
      if (!diff[DATA_W]) begin
         work_in.rem = diff[DATA_W-1:0];
         work_in.nq  = {in_work.nq[DATA_W-2:0], 1'b1};
      end else begin
         work_in.rem = trial[DATA_W-1:0];
         work_in.nq  = {in_work.nq[DATA_W-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   // Hold or advance the cell register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

@@ design/sid_post.sv @@
// Output stage of the divider: sign fix-up, saturation and result register.
// Depends on sid_pkg.
`timescale 1ns / 1ps

module sid_post (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  sid_pkg::sid_work_type          in_work,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [sid_pkg::DATA_W-1:0] rsp_quotient
);
   import sid_pkg::*;

   logic              valid_ff;
   logic [DATA_W-1:0] quot_ff;
   logic [DATA_W-1:0] quot_in;

   // Apply saturation or negate when the signs differ
   always_comb begin
      if (in_work.sat) begin
         quot_in = MAX_POS;
      end else if (in_work.neg) begin
         quot_in = DATA_W'(0) - in_work.nq;
      end else begin
         quot_in = in_work.nq;
      end
   end

   assign in_ready = !valid_ff || rsp_ready;

   // Hold the result until transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         quot_ff <= quot_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_quotient = signed'(quot_ff);

endmodule

@@ design/signed_integer_divider.sv @@
// Signed divider pipeline: input stage, 32 cells, output stage.
// Throughput one transfer per cycle when not stalled; each cell resolves one quotient bit
// and every stage has its own valid bit, so bubbles close up under back-pressure.
// Synchronous active-high reset clears all valid bits; data registers are not reset.
// Depends on sid_pkg, sid_prep, sid_cell, sid_post and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module signed_integer_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [sid_pkg::DATA_W-1:0] req_dividend,
   input  logic signed [sid_pkg::DATA_W-1:0] req_divisor,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [sid_pkg::DATA_W-1:0] rsp_quotient
);
   import sid_pkg::*;

   logic         chain_valid [DATA_W+1];
   logic         chain_ready [DATA_W+1];
   sid_work_type chain_work  [DATA_W+1];

   // Prepare magnitudes and flags
   sid_prep u_prep (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .out_valid    (chain_valid[0]),
      .out_ready    (chain_ready[0]),
      .out_work     (chain_work[0])
   );

   // Row of division cells, top quotient bit first
   for (genvar i = 0; i < DATA_W; i++) begin : g_cell
      sid_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_work   (chain_work[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_work  (chain_work[i+1])
      );
   end

   // Sign fix-up and result register
   sid_post u_post (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[DATA_W]),
      .in_ready     (chain_ready[DATA_W]),
      .in_work      (chain_work[DATA_W]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_quotient (rsp_quotient)
   );

   // Finished non-saturating items must leave a remainder below the divisor
   `ASSERT_SAME(a_rem_below_den, chain_valid[DATA_W] && !chain_work[DATA_W].sat, chain_work[DATA_W].rem < chain_work[DATA_W].den)
   // A zero divisor must be flagged for saturation at the input stage
   `ASSERT_NEXT(a_zero_div_sat, req_valid && req_ready && (req_divisor == '0), chain_valid[0] && chain_work[0].sat)
   // An empty input stage must always take a transfer
   `ASSERT_SAME(a_ready_when_empty, !chain_valid[0], req_ready)

endmodule

@@ verif/tb_signed_integer_divider.sv @@
// Self-checking bench for signed_integer_divider: directed corner divisions, then random ones.
// Random idling on both channels; quotients predicted locally and checked in order.
// Depends on sid_pkg and the divider RTL.
`timescale 1ns / 1ps

module tb_signed_integer_divider;
   import sid_pkg::*;

   localparam int IDLE_LIMIT = 2000;   // cycles with no transfer before giving up
   localparam int TAIL_CYCLES = 40;    // a little over the pipeline latency
   localparam int RANDOM_DIVISIONS = 1000;

   typedef struct {
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
      bit                drain_first;  // hold off until every quotient is back
   } division_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [DATA_W-1:0] req_dividend = '0;
   logic signed [DATA_W-1:0] req_divisor = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_quotient;

   division_type      pending_divisions[$];
   logic [DATA_W-1:0] quotients_due[$];
   int                mismatch_count = 0;
   int                in_flight = 0;
   int                send_gap = 0;
   int                send_run = 0;
   int                take_gap = 0;
   int                take_run = 0;
   int                idle_cycles = 0;

   signed_integer_divider dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_dividend (req_dividend),
      .req_divisor  (req_divisor),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_quotient (rsp_quotient)
   );

   // Truncating signed division by restoring shift-and-subtract on the magnitudes
   function automatic logic [DATA_W-1:0] expected_quotient(logic [DATA_W-1:0] dividend,
                                                           logic [DATA_W-1:0] divisor);
      logic                neg_a;
      logic                neg_d;
      logic [2*DATA_W-1:0] num;
      logic [2*DATA_W-1:0] den;
      logic [DATA_W-1:0]   q;
      neg_a = dividend[DATA_W-1];
      neg_d = divisor[DATA_W-1];
      if (divisor == '0 || (dividend == SIGN_VAL && divisor == ALL_ONES))
         return MAX_POS;
      num = {{DATA_W{1'b0}}, neg_a ? DATA_W'(-dividend) : dividend};
      den = {{DATA_W{1'b0}}, neg_d ? DATA_W'(-divisor) : divisor};
      q = '0;
      for (int b = DATA_W - 1; b >= 0; b--) begin
         q = q << 1;
         if ((num >> b) >= den) begin
            q[0] = 1'b1;
            num = num - (den << b);
         end
      end
      return (neg_a != neg_d) ? -q : q;
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Operand drawn from a mix of full-range, small, shifted, power-of-two and corner values
   function automatic logic [DATA_W-1:0] random_operand();
      logic [DATA_W-1:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         4, 5: begin
            v = $urandom_range(0, 600);
            v = v - 300;
         end
         6, 7: v = $signed(v) >>> $urandom_range(0, DATA_W - 1);
         8: begin
            case ($urandom_range(0, 4))
               0: v = '0;
               1: v = 1;
               2: v = ALL_ONES;
               3: v = SIGN_VAL;
               default: v = MAX_POS;
            endcase
         end
         9: begin
            v = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
            if ($urandom_range(0, 1) == 1) v = -v;
         end
         default: ;
      endcase
      return v;
   endfunction

   task automatic queue_division(logic [DATA_W-1:0] dividend, logic [DATA_W-1:0] divisor,
                                 bit drain_first = 1'b0);
      division_type d;
      d.dividend = dividend;
      d.divisor = divisor;
      d.drain_first = drain_first;
      pending_divisions.push_back(d);
   endtask

   task automatic note_mismatch(string what, logic [DATA_W-1:0] expected,
                                logic [DATA_W-1:0] actual);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: expected %0d, got %0d", $realtime, what,
                  $signed(expected), $signed(actual));
   endtask

   // Clock
   initial begin
      forever #2 clock = ~clock;
   end

   // Sender: present queued divisions, hold until transfer, insert random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         in_flight = 0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) in_flight++;
         if (rsp_valid && rsp_ready) in_flight--;
         if (req_valid && !req_ready) begin
            // hold the current item
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_divisions.size() != 0 &&
                      (!pending_divisions[0].drain_first || in_flight == 0)) begin
            req_valid <= 1'b1;
            req_dividend <= pending_divisions[0].dividend;
            req_divisor <= pending_divisions[0].divisor;
            void'(pending_divisions.pop_front());
            if (send_run > 0) begin
               send_run--;
            end else begin
               send_gap = pick_gap();
               if ($urandom_range(0, 49) == 0) send_run = $urandom_range(30, 150);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure with occasional stall-free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap = 0;
      end else if (take_gap > 0) begin
         take_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (take_run > 0) begin
            take_run--;
         end else begin
            take_gap = pick_gap();
            if ($urandom_range(0, 49) == 0) take_run = $urandom_range(30, 150);
         end
      end
   end

   // Check each returned quotient against the oldest prediction, then predict new transfers
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (quotients_due.size() == 0)
               note_mismatch("unexpected quotient", '0, rsp_quotient);
            else if (rsp_quotient !== quotients_due[0])
               note_mismatch("quotient mismatch", quotients_due.pop_front(), rsp_quotient);
            else
               void'(quotients_due.pop_front());
         end
         if (req_valid && req_ready)
            quotients_due.push_back(expected_quotient(req_dividend, req_divisor));
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus, reset and end of run
   initial begin
      // zero and overflow saturation
      queue_division(SIGN_VAL, ALL_ONES);
      queue_division(MAX_POS, '0);
      queue_division(SIGN_VAL, '0);
      queue_division('0, '0);
      queue_division(ALL_ONES, '0);
      // most negative operand elsewhere
      queue_division(SIGN_VAL, 1);
      queue_division(SIGN_VAL, SIGN_VAL);
      queue_division(SIGN_VAL, MAX_POS);
      queue_division(MAX_POS, SIGN_VAL);
      queue_division(SIGN_VAL, 2);
      queue_division(SIGN_VAL, -2);
      queue_division(ALL_ONES, SIGN_VAL);
      // zero dividend with either divisor sign
      queue_division('0, ALL_ONES);
      queue_division('0, SIGN_VAL);
      queue_division('0, 3);
      // largest positive and sign combinations
      queue_division(MAX_POS, MAX_POS);
      queue_division(MAX_POS, ALL_ONES);
      queue_division(MAX_POS, 1);
      queue_division(1, MAX_POS);
      queue_division(7, 2);
      queue_division(-7, 2);
      queue_division(7, -2);
      queue_division(-7, -2);
      queue_division(ALL_ONES, 1);
      queue_division(5, 5);
      // random part, draining the pipe before the first and a middle item
      for (int i = 0; i < RANDOM_DIVISIONS; i++)
         queue_division(random_operand(), random_operand(),
                        i == 0 || i == RANDOM_DIVISIONS / 2);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // wait for all transfers and quotients, then let the pipe settle
      do @(negedge clock);
      while (pending_divisions.size() != 0 || req_valid || quotients_due.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0 && quotients_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
